### sv/fwls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fwls_pkg;

    // Fixed widths of the request and result fields.
    localparam int LEN_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 9;
    localparam int SUM_W       = 24;

    // Stream payload widths (fields packed from bit 0, padded to bytes).
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 88;
    localparam int OUT_USER_W = STATUS_W;

    // Operation codes.
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DEQ,
        S_START,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the accepted request
        logic exec;        // apply an enqueue, or set the status
        logic head_rd;     // read the oldest entry
        logic deq_commit;  // retire the oldest entry
        logic scan_init;   // start a min/max scan at the head
        logic scan_rd;     // read the next entry of the scan
        logic out_load;    // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_deq;
        logic empty;
        logic scan_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

### sv/fwls_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fwls_ctrl
    import fwls_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_req_valid,
    output logic         o_req_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.op_deq && !i_sts.empty) begin
                    n_state = S_DEQ;
                end else begin
                    n_state = S_START;
                end
            end
            S_DEQ: begin
                n_state = S_START;
            end
            S_START: begin
                if (i_sts.empty) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            S_EXEC: begin
                o_cmd.exec    = 1'b1;
                o_cmd.head_rd = i_sts.op_deq && !i_sts.empty;
            end
            S_DEQ: begin
                o_cmd.deq_commit = 1'b1;
            end
            S_START: begin
                o_cmd.scan_init = 1'b1;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
            end
            S_DRAIN: begin
                o_cmd = '0;
            end
            S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // A scan never starts on an empty queue.
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START && i_sts.empty) |=> (r_state == S_DONE))
        else $error("scan entered with an empty queue");

    // A result is loaded only from the done state.
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (r_state == S_DONE))
        else $error("result loaded outside the done state");

    // The queue is touched only after a request was captured.
    a_exec_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> $past(o_cmd.load))
        else $error("request executed without being captured");

endmodule

`default_nettype wire

### sv/fwls_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module fwls_dp
    import fwls_pkg::*;
#(
    parameter int DEPTH       = 256,
    parameter int LENGTH_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_sts                     o_sts,
    input  wire logic                   i_op,
    input  wire logic [LEN_W-1:0]       i_length,
    output logic                        o_res_valid,
    input  wire logic                   i_res_ready,
    output logic [LEN_W-1:0]            o_dequeued_length,
    output logic [STATUS_W-1:0]         o_status,
    output logic [COUNT_OUT_W-1:0]      o_item_count,
    output logic [SUM_W-1:0]            o_length_sum,
    output logic [LEN_W-1:0]            o_min_length,
    output logic [LEN_W-1:0]            o_max_length
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    logic [LENGTH_BITS-1:0] r_mem [DEPTH];
    logic [LENGTH_BITS-1:0] r_rd_data;
    logic                   r_rd_vld;
    logic [IDX_W-1:0]       rd_addr;

    logic                   r_op_deq;
    logic [LENGTH_BITS-1:0] r_len;
    logic [IDX_W-1:0]       r_head;
    logic [IDX_W-1:0]       r_tail;
    logic [CNT_W-1:0]       r_count;
    logic [SUM_W-1:0]       r_sum;
    logic [STATUS_W-1:0]    r_status;
    logic [LENGTH_BITS-1:0] r_removed;
    logic [IDX_W-1:0]       r_scan_ptr;
    logic [CNT_W-1:0]       r_scan_left;
    logic [LENGTH_BITS-1:0] r_lo;
    logic [LENGTH_BITS-1:0] r_hi;
    logic                   r_out_valid;
    logic                   full;
    logic                   empty;
    logic                   out_free;

    assign full     = (r_count == CNT_W'(DEPTH));
    assign empty    = (r_count == '0);
    assign out_free = !r_out_valid || i_res_ready;

    assign o_sts.op_deq    = r_op_deq;
    assign o_sts.empty     = empty;
    assign o_sts.scan_last = (r_scan_left == CNT_W'(1));
    assign o_sts.out_free  = out_free;

    assign rd_addr = i_cmd.scan_rd ? r_scan_ptr : r_head;

    // Ring store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !r_op_deq && !full) begin
            r_mem[r_tail] <= r_len;
        end
        if (i_cmd.head_rd || i_cmd.scan_rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Captured request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op_deq <= (i_op == OP_DEQ);
            r_len    <= LENGTH_BITS'(i_length);
        end
    end

    // Queue pointers, count and running sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_cmd.exec && !r_op_deq && !full) begin
            r_tail  <= (r_tail == LAST_IDX) ? '0 : r_tail + IDX_W'(1);
            r_count <= r_count + CNT_W'(1);
            r_sum   <= r_sum + SUM_W'(r_len);
        end else if (i_cmd.deq_commit) begin
            r_head  <= (r_head == LAST_IDX) ? '0 : r_head + IDX_W'(1);
            r_count <= r_count - CNT_W'(1);
            r_sum   <= r_sum - SUM_W'(r_rd_data);
        end
    end

    // Status and removed value of the current request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_removed <= '0;
            if (r_op_deq) begin
                r_status <= empty ? STAT_EMPTY : STAT_OK;
            end else begin
                r_status <= full ? STAT_FULL : STAT_OK;
            end
        end else if (i_cmd.deq_commit) begin
            r_removed <= r_rd_data;
        end
    end

    // Scan address walk over the held entries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
        end
        if (i_cmd.scan_init) begin
            r_scan_ptr  <= r_head;
            r_scan_left <= r_count;
        end else if (i_cmd.scan_rd) begin
            r_scan_ptr  <= (r_scan_ptr == LAST_IDX) ? '0 : r_scan_ptr + IDX_W'(1);
            r_scan_left <= r_scan_left - CNT_W'(1);
        end
    end

    // Running minimum and maximum, one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_lo <= '1;
            r_hi <= '0;
        end else if (r_rd_vld) begin
            if (r_rd_data < r_lo) begin
                r_lo <= r_rd_data;
            end
            if (r_rd_data > r_hi) begin
                r_hi <= r_rd_data;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            o_dequeued_length <= LEN_W'(r_removed);
            o_status          <= r_status;
            o_item_count      <= COUNT_OUT_W'(r_count);
            o_length_sum      <= r_sum;
            o_min_length      <= empty ? '0 : LEN_W'(r_lo);
            o_max_length      <= empty ? '0 : LEN_W'(r_hi);
        end
    end

    assign o_res_valid = r_out_valid;

    // The count never exceeds the ring size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above ring size");

    // An empty ring has its pointers together.
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        empty |-> (r_head == r_tail))
        else $error("empty ring with head and tail apart");

    // An accepted enqueue grows the count by one.
    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && !r_op_deq && !full) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("enqueue did not grow the count");

    // A loaded result is presented on the next cycle.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

### sv/fifo_with_length_statistics.sv
// First-in first-out queue of length values with running statistics. A request on the
// slave stream either enqueues a length (tuser 0) or dequeues the oldest one (tuser 1);
// each request gives exactly one result on the master stream with the dequeued length,
// a status (ok, dequeue from empty, enqueue into full), the entry count, the 24-bit sum
// of the held lengths, and the minimum and maximum of the held lengths (zero when the
// queue is empty). The average is left to the consumer. Requests are handled one at a
// time. After acceptance a request is executed, a successful dequeue then retires the
// oldest entry, and a min/max scan reads the single read port of the ring store once
// per held entry (skipped when the queue is left empty) before the result is loaded.
// The next request is accepted in the cycle after the load at the earliest. A finished
// result waits in an output register; a result that is still waiting holds the block
// in its last step until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module fifo_with_length_statistics
    import fwls_pkg::*;
#(
    parameter int DEPTH       = 256,
    parameter int LENGTH_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,   // [15:0] length_value
    input  wire logic [IN_USER_W-1:0]  i_s_tuser,   // [0] operation
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0]      o_m_tdata,   // [15:0] dequeued_length,
                                                    // [24:16] item_count,
                                                    // [48:25] length_sum,
                                                    // [64:49] min_length,
                                                    // [80:65] max_length, rest zero
    output logic [OUT_USER_W-1:0]      o_m_tuser    // [1:0] status
);

    t_dp_cmd                 cmd;
    t_dp_sts                 sts;
    logic [LEN_W-1:0]        dequeued_length;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_OUT_W-1:0]  item_count;
    logic [SUM_W-1:0]        length_sum;
    logic [LEN_W-1:0]        min_length;
    logic [LEN_W-1:0]        max_length;

    // Request sequencing.
    fwls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Ring store, counters and scan.
    fwls_dp #(
        .DEPTH       (DEPTH),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_op              (i_s_tuser[0]),
        .i_length          (i_s_tdata[LEN_W-1:0]),
        .o_res_valid       (o_m_tvalid),
        .i_res_ready       (i_m_tready),
        .o_dequeued_length (dequeued_length),
        .o_status          (status),
        .o_item_count      (item_count),
        .o_length_sum      (length_sum),
        .o_min_length      (min_length),
        .o_max_length      (max_length)
    );

    // Result packing.
    assign o_m_tdata = {7'd0, max_length, min_length, length_sum, item_count,
                        dequeued_length};
    assign o_m_tuser = status;

endmodule

`default_nettype wire
